FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the timeout wheel RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define A_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define A_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hw/rtl/btw_pkg.sv
// Shared types and constants of the timeout wheel
`timescale 1ns / 1ps
package btw_pkg;
    localparam int OP_SET = 0;
    localparam int OP_ADV = 1;
    localparam int WHEEL_SLOTS = 128;
    localparam int SLOT_W = $clog2(WHEEL_SLOTS);
    typedef struct packed {
        logic        op;
        logic [5:0]  fd;
        logic [15:0] seconds;
        logic [31:0] now_time;
    } t_item;
endpackage

FILE: hw/rtl/btw_front.sv
// Front end: accepts input beats into a short queue
`timescale 1ns / 1ps
module btw_front
    import btw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item r_q [2];
    logic [1:0] r_cnt;
    logic r_rd, r_wr;
    logic push, pop;
    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rd];
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_item;
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= 1'b0; r_wr <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: hw/rtl/btw_back.sv
// Back end: wheel storage, divider and slot scan
`timescale 1ns / 1ps
module btw_back
    import btw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_res,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_fd,
    output logic        o_last
);
    `include "assert_macros.svh"
    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_LOOK = 10'b0000000100,
        S_DIS  = 10'b0000001000,
        S_DIV  = 10'b0000010000,
        S_ARM  = 10'b0000100000,
        S_PUT  = 10'b0001000000,
        S_SCAN = 10'b0010000000,
        S_EMIT = 10'b0100000000,
        S_LAST = 10'b1000000000
    } t_state;
    t_state r_st;
    // per-slot 64-bit map; descriptor valid bits and slot numbers
    logic [63:0] r_mem [WHEEL_SLOTS];
    logic [63:0] r_rdata;
    logic [63:0] r_armed;
    logic [SLOT_W-1:0] r_fslot [64];
    logic [SLOT_W-1:0] r_fs_q;
    logic [SLOT_W-1:0] r_base, r_slot;
    logic [31:0] r_bsec, r_cur;
    t_item r_it;
    logic [15:0] r_r;
    logic [32:0] r_num;
    logic [32:0] r_rem, r_quo;
    logic [5:0] r_cnt;
    logic [SLOT_W:0] r_left;
    logic [63:0] r_word;
    logic r_ph, r_pv;
    logic [5:0] r_pfd;
    logic [5:0] r_fd;
    logic r_last, r_ov;
    logic [5:0] pos;
    logic found, out_free, emit_mid, emit_end, mem_we;
    logic [63:0] fd_bit, mem_wd;
    logic [33:0] trial;
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_fd = r_fd;
    assign o_last = r_last;
    assign out_free = !r_ov || i_ready;
    // the held descriptor goes out once the next one is found or the scan ends
    assign emit_mid = (r_st == S_EMIT) && found && r_pv && out_free;
    assign emit_end = (r_st == S_LAST) && out_free;
    assign fd_bit = 64'd1 << r_it.fd;
    assign mem_we = (r_st == S_CLR)
        || (r_ph && ((r_st == S_DIS) || (r_st == S_PUT) || (r_st == S_SCAN)));
    assign mem_wd = (r_st == S_DIS) ? (r_rdata & ~fd_bit)
        : (r_st == S_PUT) ? (r_rdata | fd_bit) : '0;
    always_comb begin
        pos = '0; found = 1'b0;
        for (int k = 63; k >= 0; k--) if (r_word[k]) begin
            pos = 6'(k); found = 1'b1;
        end
    end
    assign trial = {r_rem, r_num[32]} - {18'd0, r_r};
    // slot store: one registered read and one write a cycle, both at r_slot
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_slot] <= mem_wd;
        r_rdata <= r_mem[r_slot];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_last <= 1'b0; r_fd <= '0;
        end else if (emit_mid || emit_end) begin
            r_ov <= 1'b1; r_fd <= r_pfd; r_last <= emit_end;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        r_fs_q <= r_fslot[i_item.fd];
        if (!i_rst_n) begin
            r_st <= S_CLR; r_slot <= '0; r_armed <= '0; r_base <= '0; r_bsec <= '0;
            r_cur <= '0; r_ph <= 1'b0; r_pv <= 1'b0;
        end else begin
            unique case (r_st)
                S_CLR: begin
                    r_slot <= r_slot + SLOT_W'(1);
                    if (r_slot == SLOT_W'(WHEEL_SLOTS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_it <= i_item;
                    r_r <= (i_res == 16'd0) ? 16'd1 : i_res;
                    r_cnt <= 6'd32; r_rem <= '0; r_quo <= '0;
                    if (i_item.op == 1'(OP_SET)) begin
                        r_num <= ({1'b0, r_cur} + {17'd0, i_item.seconds} >= {1'b0, r_bsec})
                            ? {1'b0, r_cur} + {17'd0, i_item.seconds} - {1'b0, r_bsec} : '0;
                        if (r_armed[i_item.fd]) r_st <= S_LOOK;
                        else if (i_item.seconds == 16'd0) r_st <= S_IDLE;
                        else r_st <= S_DIV;
                    end else begin
                        r_cur <= i_item.now_time;
                        r_num <= {1'b0, i_item.now_time - r_bsec};
                        r_st <= (i_item.now_time < r_bsec) ? S_IDLE : S_DIV;
                    end
                end
                S_LOOK: begin
                    r_slot <= r_fs_q; r_ph <= 1'b0; r_st <= S_DIS;
                end
                S_DIS: begin
                    // wait for the registered read, then drop the bit
                    if (r_ph) begin
                        r_armed[r_it.fd] <= 1'b0;
                        r_st <= (r_it.seconds == 16'd0) ? S_IDLE : S_DIV;
                    end
                    r_ph <= ~r_ph;
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (!trial[33]) begin
                        r_rem <= trial[32:0]; r_quo <= {r_quo[31:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], r_num[32]}; r_quo <= {r_quo[31:0], 1'b0};
                    end
                    r_num <= {r_num[31:0], 1'b0};
                    if (r_cnt == 6'd0) r_st <= S_ARM;
                    r_cnt <= r_cnt - 6'd1;
                end
                S_ARM: begin
                    if (r_it.op == 1'(OP_SET)) begin
                        r_slot <= r_base + ((r_quo >= 33'(WHEEL_SLOTS - 1))
                            ? SLOT_W'(WHEEL_SLOTS - 1) : r_quo[SLOT_W-1:0]);
                        r_ph <= 1'b0;
                        r_st <= S_PUT;
                    end else if (r_quo == '0) r_st <= S_IDLE;
                    else begin
                        r_left <= (r_quo >= 33'(WHEEL_SLOTS)) ? (SLOT_W+1)'(WHEEL_SLOTS)
                            : r_quo[SLOT_W:0];
                        r_slot <= r_base; r_ph <= 1'b0; r_pv <= 1'b0;
                        r_st <= S_SCAN;
                    end
                end
                S_PUT: begin
                    if (r_ph) begin
                        r_armed[r_it.fd] <= 1'b1;
                        r_fslot[r_it.fd] <= r_slot;
                        r_st <= S_IDLE;
                    end
                    r_ph <= ~r_ph;
                end
                S_SCAN: begin
                    // wait for the registered read
                    if (r_ph) begin
                        r_word <= r_rdata;
                        r_armed <= r_armed & ~r_rdata;
                        r_st <= S_EMIT;
                    end
                    r_ph <= ~r_ph;
                end
                S_EMIT: begin
                    if (found) begin
                        if (!r_pv || out_free) begin
                            r_pv <= 1'b1; r_pfd <= pos; r_word[pos] <= 1'b0;
                        end
                    end else if (r_left == (SLOT_W+1)'(1)) begin
                        r_base <= r_base + r_quo[SLOT_W-1:0];
                        r_bsec <= r_bsec + 32'(r_quo[31:0] * {16'd0, r_r});
                        r_st <= r_pv ? S_LAST : S_IDLE;
                    end else begin
                        r_slot <= r_slot + SLOT_W'(1);
                        r_left <= r_left - (SLOT_W+1)'(1);
                        r_ph <= 1'b0; r_st <= S_SCAN;
                    end
                end
                S_LAST: if (out_free) begin
                    r_pv <= 1'b0; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
    `A_ALWAYS(a_ready_idle, i_clk, i_rst_n, o_ready == (r_st == S_IDLE), "ready off idle")
    `A_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_fd) && $stable(o_last), "result changed while held")
    `A_ALWAYS(a_left, i_clk, i_rst_n, r_st != S_EMIT || r_left != '0, "scan count underflow")
    `A_ALWAYS(a_last_pend, i_clk, i_rst_n, r_st != S_LAST || r_pv, "final beat without descriptor")
endmodule

FILE: hw/rtl/bitmap_timeout_wheel_top.sv
// Top level of the bitmap timeout wheel
`timescale 1ns / 1ps
// Descriptor timeout wheel with 128 slots. After reset the slot store is cleared
// while the input is held off. A two-beat queue takes input beats while the back
// end works. A set beat is taken, divided bit-serially by the slot resolution,
// placed in a slot and written with a read-modify-write of the slot map; removing
// a descriptor from its old slot first adds a lookup and a read-modify-write. A
// set with zero seconds only removes. An advance stops when time is behind the
// base, and after the divide when nothing is due; otherwise it scans each due
// slot (at most 128), sends the expired descriptors one at a time while the
// output is free, and the last of them goes out as the final beat. A stalled
// output holds the scan.
module bitmap_timeout_wheel_top
    import btw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // fd[5:0], seconds[21:6], now_time[53:22], zero pad
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // expired_fd[5:0], zero pad
    output logic        m_axis_tlast
);
    logic [15:0] r_res;
    t_item in_item, q_item;
    logic q_valid, q_ready;
    logic [5:0] fd;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_res <= 16'd1;
        else if (i_cfg_valid) r_res <= i_cfg_data;
    end
    assign in_item = '{op: s_axis_tuser, fd: s_axis_tdata[5:0],
                       seconds: s_axis_tdata[21:6], now_time: s_axis_tdata[53:22]};
    btw_front u_front (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_item(in_item), .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item));
    btw_back u_back (.i_clk, .i_rst_n, .i_res(r_res),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_fd(fd), .o_last(m_axis_tlast));
    assign m_axis_tdata = {2'b00, fd};
endmodule

FILE: tb/tb_bitmap_timeout_wheel_top.sv
// Self-checking testbench for the bitmap timeout wheel: random set/advance beats against a model
`timescale 1ns / 1ps
module tb_bitmap_timeout_wheel_top
    import btw_pkg::*;
();

    localparam int SLOTS = 128;
    localparam int NFD = 64;
    localparam int CYCLE_LIMIT = 3000000;

    class expiry_scoreboard;
        logic [63:0] slot_map [SLOTS];
        bit          armed [NFD];
        logic [6:0]  armed_slot [NFD];
        logic [6:0]  base_slot;
        logic [31:0] base_secs;
        logic [31:0] cur_secs;
        logic [15:0] resolution;
        logic [6:0]  exp_fd_q [$];
        bit          exp_last_q [$];
        int          errors;

        function new();
            errors = 0;
            base_slot = 0;
            base_secs = 0;
            cur_secs = 0;
            resolution = 1;
            for (int i = 0; i < SLOTS; i++) slot_map[i] = '0;
            for (int i = 0; i < NFD; i++) begin
                armed[i] = 0;
                armed_slot[i] = 0;
            end
        endfunction

        function void set_resolution(logic [15:0] r);
            resolution = r;
        endfunction

        // Predict the expiries caused by one accepted input beat.
        function void note_item(logic op, logic [5:0] fd, logic [15:0] secs, logic [31:0] now);
            logic [63:0] res, top, num, delta, due, scan;
            int n;
            res = (resolution == 0) ? 64'd1 : {48'd0, resolution};
            if (op == 1'(OP_SET)) begin
                if (armed[fd]) begin
                    slot_map[armed_slot[fd]][fd] = 1'b0;
                    armed[fd] = 0;
                end
                if (secs != 0) begin
                    top = {32'd0, cur_secs} + {48'd0, secs};
                    num = (top >= {32'd0, base_secs}) ? top - {32'd0, base_secs} : 64'd0;
                    delta = num / res;
                    if (delta >= SLOTS) delta = 64'(SLOTS - 1);
                    armed_slot[fd] = base_slot + delta[6:0];
                    slot_map[armed_slot[fd]][fd] = 1'b1;
                    armed[fd] = 1;
                end
            end else begin
                cur_secs = now;
                if (cur_secs < base_secs) return;
                due = ({32'd0, cur_secs} - {32'd0, base_secs}) / res;
                if (due == 0) return;
                scan = (due < SLOTS) ? due : 64'(SLOTS);
                n = 0;
                for (int i = 0; i < scan; i++) begin
                    logic [6:0] s;
                    s = base_slot + 7'(i);
                    for (int b = 0; b < NFD; b++) begin
                        if (slot_map[s][b]) begin
                            armed[b] = 0;
                            exp_fd_q.push_back(7'(b));
                            exp_last_q.push_back(1'b0);
                            n++;
                        end
                    end
                    slot_map[s] = '0;
                end
                base_slot = base_slot + due[6:0];
                base_secs = base_secs + 32'(due * res);
                if (n > 0) exp_last_q[$] = 1'b1;
            end
        endfunction

        function void check_expiry(logic [7:0] data, logic last);
            logic [6:0] efd;
            bit elast;
            if (exp_fd_q.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual fd %0d last %0b",
                         $time, data[5:0], last);
                errors++;
                return;
            end
            efd = exp_fd_q.pop_front();
            elast = exp_last_q.pop_front();
            if (data !== {2'b00, efd[5:0]}) begin
                $display("%0t: expired_fd mismatch: expected %0d, actual %0d",
                         $time, efd[5:0], data);
                errors++;
            end
            if (last !== elast) begin
                $display("%0t: last mismatch: expected %0b, actual %0b", $time, elast, last);
                errors++;
            end
        endfunction

        function int pending();
            return exp_fd_q.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    expiry_scoreboard sb = new();
    int  cycles = 0;
    int  hold_off = 0;
    bit  stall_go = 0;
    bit  stall_seen = 0;
    bit  quiet_rx = 0;
    logic [31:0] clock_secs = 0;

    bitmap_timeout_wheel_top dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: its own stall pattern, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_expiry(m_axis_tdata, m_axis_tlast);
        if (stall_go != stall_seen) begin
            stall_seen <= stall_go;
            hold_off <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (quiet_rx) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_item(logic op, logic [5:0] fd, logic [15:0] secs, logic [31:0] now);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, now, secs, fd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(op, fd, secs, now);
    endtask

    task automatic idle(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        // an advance may still be scanning empty slots
        repeat (1000) @(posedge i_clk);
    endtask

    task automatic write_resolution(logic [15:0] r);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_resolution(r);
    endtask

    task automatic advance_by(logic [31:0] step);
        clock_secs = clock_secs + step;
        send_item(1'(OP_ADV), 6'($urandom), 16'($urandom), clock_secs);
    endtask

    task automatic random_phase(int count, int max_secs, int max_step);
        int burst;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 30));
            end
            burst--;
            if ($urandom_range(0, 2) == 0)
                advance_by($urandom_range(0, max_step));
            else
                send_item(1'(OP_SET), 6'($urandom), 16'($urandom_range(0, max_secs)),
                          $urandom);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, clears, saturation, behind-base set, time going back
        send_item(1'(OP_SET), 6'd0, 16'd1, 32'hFFFF_FFFF);
        send_item(1'(OP_SET), 6'd63, 16'hFFFF, 32'd0);
        send_item(1'(OP_SET), 6'd17, 16'd5, 32'd0);
        send_item(1'(OP_SET), 6'd17, 16'd0, 32'd0);
        send_item(1'(OP_SET), 6'd42, 16'd3, 32'd0);
        send_item(1'(OP_SET), 6'd5, 16'd3, 32'd0);
        advance_by(0);
        advance_by(1);
        advance_by(3);
        send_item(1'(OP_ADV), 6'h3F, 16'hFFFF, 32'd0);
        send_item(1'(OP_SET), 6'd9, 16'd1, 32'd0);
        send_item(1'(OP_SET), 6'd10, 16'd2, 32'd0);
        clock_secs = 4;
        advance_by(500);
        send_item(1'(OP_ADV), 6'd0, 16'd0, 32'h8000_0000);
        clock_secs = 32'h8000_0000;
        drain();

        write_resolution(16'd0);
        for (int i = 0; i < NFD; i++) send_item(1'(OP_SET), 6'(i), 16'd2, $urandom);
        advance_by(2);
        drain();

        write_resolution(16'hFFFF);
        random_phase(60, 16'hFFFF, 70000);
        drain();

        write_resolution(16'd3);
        quiet_rx = 1;
        for (int i = 0; i < NFD; i++) send_item(1'(OP_SET), 6'(i), 16'd1, $urandom);
        stall_go = ~stall_go;
        for (int i = 0; i < 20; i++) begin
            send_item(1'(OP_SET), 6'($urandom), 16'($urandom_range(1, 10)), $urandom);
            advance_by($urandom_range(0, 4));
        end
        drain();
        quiet_rx = 0;

        write_resolution(16'd1);
        random_phase(100, 200, 20);
        drain();

        write_resolution(16'd7);
        random_phase(70, 1200, 60);
        advance_by(2000);
        send_item(1'(OP_ADV), 6'd0, 16'd0, 32'hFFFF_FFFF);
        send_item(1'(OP_SET), 6'd3, 16'hFFFF, 32'd0);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
